>>> rtl/core/nrmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrmc_pkg
// Character codes, status codes and helpers for the RMC sentence checker.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    typedef logic [7:0] t_char;
    typedef logic [2:0] t_status;
    typedef logic [3:0] t_field_idx;
    typedef logic [2:0] t_char_off;

    localparam t_char CH_DOLLAR = 8'h24;
    localparam t_char CH_COMMA  = 8'h2C;
    localparam t_char CH_A      = 8'h41;
    localparam t_char CH_G      = 8'h47;
    localparam t_char CH_P      = 8'h50;
    localparam t_char CH_R      = 8'h52;
    localparam t_char CH_M      = 8'h4D;
    localparam t_char CH_C      = 8'h43;

    localparam t_field_idx FIELD_TYPE  = 4'd0;
    localparam t_field_idx FIELD_VALID = 4'd2;
    localparam t_field_idx FIELD_DATE  = 4'd9;

    localparam t_char_off TYPE_LEN = 3'd5;
    localparam t_char_off OFF_MAX  = 3'd7;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_INCOMPLETE = 3'd1;
    localparam t_status ST_BAD_G      = 3'd2;
    localparam t_status ST_BAD_P      = 3'd3;
    localparam t_status ST_BAD_R      = 3'd4;
    localparam t_status ST_BAD_M      = 3'd5;
    localparam t_status ST_BAD_C      = 3'd6;
    localparam t_status ST_NOT_VALID  = 3'd7;

    // expected letter of the sentence type at a given offset ("GPRMC")
    function automatic t_char type_letter(input t_char_off off);
        t_char letter;
        begin
            case (off)
                3'd0:    letter = CH_G;
                3'd1:    letter = CH_P;
                3'd2:    letter = CH_R;
                3'd3:    letter = CH_M;
                3'd4:    letter = CH_C;
                default: letter = 8'h00;
            endcase
            return letter;
        end
    endfunction

endpackage : nrmc_pkg
`default_nettype wire

>>> rtl/core/nmea_rmc_sentence_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_checker
// Streaming checker for NMEA 0183 RMC sentences, one character per word.
// ----------------------------------------------------------------------------
// Feed received bytes in on the slave side, one per word. A '$' opens a
// sentence; commas split it into fields. On the comma closing field 0 the
// type is checked against "GPRMC" (first failure reported in the order C, M,
// R, P, G; a missing letter is a failure). On the comma closing field 2 the
// field must begin with 'A', otherwise "not valid". On the comma closing
// field 9 (date) "ok" is reported. After any verdict bytes are ignored until
// the next '$'. A '$' that arrives while a sentence is still undecided
// reports "incomplete" and then starts the new sentence. At most one status
// word comes out per input word. Rate: one word per clock while the output
// is not stalled; each word is held in the input register, where the
// sentence state is updated, and its status (if any) then sits in the output
// register. The output register lets a new input word in while a status
// waits to be taken.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // slave side: received characters
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] rx_char
    // master side: sentence status
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] status, [7:3] zero
);

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic               r_in_valid;
    nrmc_pkg::t_char    r_in_char;
    logic               r_out_valid;
    nrmc_pkg::t_status  r_out_status;

    logic advance;     // input register word is processed this cycle
    logic s_accept;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Sentence state
    // ------------------------------------------------------------------
    logic                   r_in_sentence,   n_in_sentence;
    logic                   r_verdict,       n_verdict;
    nrmc_pkg::t_field_idx   r_field,         n_field;
    nrmc_pkg::t_char_off    r_offset,        n_offset;
    logic [4:0]             r_type_ok,       n_type_ok;
    logic                   r_valid_ok,      n_valid_ok;

    logic               res_hit;     // this word yields a status
    nrmc_pkg::t_status  res_status;

    always_comb begin
        n_in_sentence = r_in_sentence;
        n_verdict     = r_verdict;
        n_field       = r_field;
        n_offset      = r_offset;
        n_type_ok     = r_type_ok;
        n_valid_ok    = r_valid_ok;
        res_hit       = 1'b0;
        res_status    = nrmc_pkg::ST_OK;

        if (r_in_char == nrmc_pkg::CH_DOLLAR) begin
            // restart; undecided sentence is reported incomplete
            res_hit       = r_in_sentence && !r_verdict;
            res_status    = nrmc_pkg::ST_INCOMPLETE;
            n_in_sentence = 1'b1;
            n_verdict     = 1'b0;
            n_field       = '0;
            n_offset      = '0;
            n_type_ok     = '0;
            n_valid_ok    = 1'b0;
        end else if (r_in_sentence && !r_verdict) begin
            if (r_in_char == nrmc_pkg::CH_COMMA) begin
                n_field  = r_field + 4'd1;
                n_offset = '0;
                if (r_field == nrmc_pkg::FIELD_TYPE) begin
                    // checked last letter first
                    res_hit = (r_type_ok != 5'h1F);
                    if (!r_type_ok[4])      res_status = nrmc_pkg::ST_BAD_C;
                    else if (!r_type_ok[3]) res_status = nrmc_pkg::ST_BAD_M;
                    else if (!r_type_ok[2]) res_status = nrmc_pkg::ST_BAD_R;
                    else if (!r_type_ok[1]) res_status = nrmc_pkg::ST_BAD_P;
                    else                    res_status = nrmc_pkg::ST_BAD_G;
                end else if (r_field == nrmc_pkg::FIELD_VALID) begin
                    res_hit    = !r_valid_ok;
                    res_status = nrmc_pkg::ST_NOT_VALID;
                end else if (r_field == nrmc_pkg::FIELD_DATE) begin
                    res_hit    = 1'b1;
                    res_status = nrmc_pkg::ST_OK;
                end
                n_verdict = res_hit;
            end else begin
                if (r_field == nrmc_pkg::FIELD_TYPE && r_offset < nrmc_pkg::TYPE_LEN) begin
                    if (r_in_char == nrmc_pkg::type_letter(r_offset))
                        n_type_ok[r_offset] = 1'b1;
                end else if (r_field == nrmc_pkg::FIELD_VALID && r_offset == '0) begin
                    if (r_in_char == nrmc_pkg::CH_A)
                        n_valid_ok = 1'b1;
                end
                if (r_offset != nrmc_pkg::OFF_MAX)
                    n_offset = r_offset + 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_in_sentence <= 1'b0;
            r_verdict     <= 1'b0;
            r_field       <= '0;
            r_offset      <= '0;
            r_type_ok     <= '0;
            r_valid_ok    <= 1'b0;
        end else begin
            if (s_axis_tready)
                r_in_valid <= s_axis_tvalid;
            if (advance) begin
                r_out_valid <= r_in_valid && res_hit;
                if (r_in_valid) begin
                    r_in_sentence <= n_in_sentence;
                    r_verdict     <= n_verdict;
                    r_field       <= n_field;
                    r_offset      <= n_offset;
                    r_type_ok     <= n_type_ok;
                    r_valid_ok    <= n_valid_ok;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept)
            r_in_char <= s_axis_tdata;
        if (advance && r_in_valid)
            r_out_status <= res_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_status};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // a verdict only exists inside a sentence
    a_verdict_in_sentence : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_verdict |-> r_in_sentence)
        else $error("verdict flag set outside a sentence");

    // an undecided sentence never runs past the date field
    a_field_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_verdict |-> (r_field <= nrmc_pkg::FIELD_DATE))
        else $error("field counter past date while undecided");

    // every pending status other than incomplete leaves the sentence decided
    a_status_decides : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != nrmc_pkg::ST_INCOMPLETE) |-> r_verdict)
        else $error("status pending without verdict");

    // sentence state does not move while a status is stalled
    a_hold_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_field) && $stable(r_verdict))
        else $error("state changed while output stalled");
`endif

endmodule : nmea_rmc_sentence_checker
`default_nettype wire

>>> test/nmea_rmc_sentence_checker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_checker_test
// Self-checking bench: feeds characters, predicts sentence status, compares.
// ----------------------------------------------------------------------------
// A short table of hand-picked characters comes first. It covers bytes outside a
// sentence, an empty and a short type field, an over-long type field, an empty
// validity field and a restart before the verdict. A stream of random sentences
// follows: mostly well formed, some with a corrupt or truncated type, some
// invalid, some cut short, and bursts of raw noise. Every accepted character
// goes through a local sentence tracker. Each status word that comes out is
// matched against the oldest status still due. Both ports idle at random.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_checker_test;

    localparam int RANDOM_CHARS   = 1650;  // characters sent in the random part
    localparam int SETTLE_CYCLES  = 8;     // settle margin after the last status is drained
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word on either side

    localparam nrmc_pkg::t_char CH_STAR = 8'h2A;
    localparam nrmc_pkg::t_char CH_V    = 8'h56;
    localparam nrmc_pkg::t_char CH_CR   = 8'h0D;
    localparam nrmc_pkg::t_char CH_LF   = 8'h0A;

    // sentence type letters by offset
    localparam nrmc_pkg::t_char RMC_TYPE [5] = '{nrmc_pkg::CH_G, nrmc_pkg::CH_P,
                                                 nrmc_pkg::CH_R, nrmc_pkg::CH_M,
                                                 nrmc_pkg::CH_C};

    // how a table row gets its expectation
    typedef enum logic [1:0] {
        ROW_PREDICTED,  // from the tracker
        ROW_SILENT,     // typed: no status word
        ROW_STATUS      // typed: the status in the row
    } t_row_kind;

    typedef struct packed {
        nrmc_pkg::t_char   ch;
        t_row_kind         kind;
        nrmc_pkg::t_status st;
    } t_row;

    localparam int DIR_LEN = 25;
    localparam t_row DIR_ROWS [DIR_LEN] = '{
        '{8'hFF,               ROW_SILENT,    nrmc_pkg::ST_OK},  // no sentence yet
        '{8'h00,               ROW_SILENT,    nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_DOLLAR, ROW_SILENT,    nrmc_pkg::ST_OK},  // nothing to close
        '{nrmc_pkg::CH_COMMA,  ROW_STATUS,    nrmc_pkg::ST_BAD_C},  // empty type
        '{8'h78,               ROW_SILENT,    nrmc_pkg::ST_OK},  // after verdict
        '{nrmc_pkg::CH_DOLLAR, ROW_SILENT,    nrmc_pkg::ST_OK},  // restart, decided
        '{nrmc_pkg::CH_G,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_P,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_DOLLAR, ROW_STATUS,    nrmc_pkg::ST_INCOMPLETE},  // undecided
        '{nrmc_pkg::CH_G,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_P,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_R,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_M,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_C,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{8'h58,               ROW_PREDICTED, nrmc_pkg::ST_OK},  // sixth, unchecked
        '{nrmc_pkg::CH_COMMA,  ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{CH_STAR,             ROW_PREDICTED, nrmc_pkg::ST_OK},  // plain field char
        '{nrmc_pkg::CH_COMMA,  ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_COMMA,  ROW_STATUS,    nrmc_pkg::ST_NOT_VALID},  // empty
        '{nrmc_pkg::CH_DOLLAR, ROW_SILENT,    nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_G,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_P,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_R,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_M,      ROW_PREDICTED, nrmc_pkg::ST_OK},
        '{nrmc_pkg::CH_COMMA,  ROW_STATUS,    nrmc_pkg::ST_BAD_C}   // C missing
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] rx_char
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [2:0] status, [7:3] zero

    // sentence tracker state
    bit                   open_s;        // a '$' has been seen since reset
    bit                   decided_s;     // current sentence already has its verdict
    nrmc_pkg::t_field_idx field_s;
    nrmc_pkg::t_char_off  offset_s;      // saturates at OFF_MAX
    logic [4:0]           letters_ok_s;  // type letter i matched
    bit                   valid_s;       // validity field began with 'A'

    nrmc_pkg::t_status pending_status [$];
    int      mismatches  = 0;
    int      sent_chars  = 0;
    int      idle_cycles = 0;
    bit      tx_calm     = 1'b0;
    bit      rx_calm     = 1'b0;
    int      rx_hold     = 0;

    nmea_rmc_sentence_checker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Advance the tracker by one character; returns 1 when a status is due.
    function automatic bit rmc_predict(input nrmc_pkg::t_char c,
                                       output nrmc_pkg::t_status st);
        bit                   undecided;
        nrmc_pkg::t_field_idx closed;
        st = nrmc_pkg::ST_OK;
        if (c == nrmc_pkg::CH_DOLLAR) begin
            undecided    = open_s && !decided_s;
            open_s       = 1'b1;
            decided_s    = 1'b0;
            field_s      = nrmc_pkg::FIELD_TYPE;
            offset_s     = '0;
            letters_ok_s = '0;
            valid_s      = 1'b0;
            st           = nrmc_pkg::ST_INCOMPLETE;
            return undecided;
        end
        if (!open_s || decided_s)
            return 1'b0;
        if (c == nrmc_pkg::CH_COMMA) begin
            closed   = field_s;
            field_s  = field_s + 4'd1;
            offset_s = '0;
            if (closed == nrmc_pkg::FIELD_TYPE) begin
                // first missing letter wins, checked from C back to G
                for (int i = 4; i >= 0; i--) begin
                    if (!letters_ok_s[i]) begin
                        decided_s = 1'b1;
                        st        = nrmc_pkg::t_status'(nrmc_pkg::ST_BAD_G + i);
                        return 1'b1;
                    end
                end
            end else if (closed == nrmc_pkg::FIELD_VALID) begin
                if (!valid_s) begin
                    decided_s = 1'b1;
                    st        = nrmc_pkg::ST_NOT_VALID;
                    return 1'b1;
                end
            end else if (closed == nrmc_pkg::FIELD_DATE) begin
                decided_s = 1'b1;
                st        = nrmc_pkg::ST_OK;
                return 1'b1;
            end
            return 1'b0;
        end
        if (field_s == nrmc_pkg::FIELD_TYPE && offset_s < nrmc_pkg::TYPE_LEN) begin
            if (c == RMC_TYPE[offset_s])
                letters_ok_s[offset_s] = 1'b1;
        end else if (field_s == nrmc_pkg::FIELD_VALID && offset_s == '0) begin
            if (c == nrmc_pkg::CH_A)
                valid_s = 1'b1;
        end
        if (offset_s != nrmc_pkg::OFF_MAX)
            offset_s = offset_s + 3'd1;
        return 1'b0;
    endfunction

    // mostly back to back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // any byte that neither opens a sentence nor closes a field
    function automatic nrmc_pkg::t_char field_char();
        nrmc_pkg::t_char c;
        do begin
            if ($urandom_range(0, 19) == 0)
                c = nrmc_pkg::t_char'($urandom_range(0, 255));
            else
                c = nrmc_pkg::t_char'($urandom_range(8'h20, 8'h7E));
        end while (c == nrmc_pkg::CH_DOLLAR || c == nrmc_pkg::CH_COMMA);
        return c;
    endfunction

    // Present one word, wait for it to be taken, then log what it makes due.
    task automatic send_char(input nrmc_pkg::t_char c, input t_row_kind kind,
                             input nrmc_pkg::t_status typed);
        int                gap;
        bit                due;
        nrmc_pkg::t_status st;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_chars++;
        due = rmc_predict(c, st);
        case (kind)
            ROW_PREDICTED: begin
                if (due)
                    pending_status.push_back(st);
            end
            ROW_STATUS: begin
                pending_status.push_back(typed);
            end
            default: ;
        endcase
    endtask

    // sender holds off until every status word due has come out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // One random sentence, or a burst of noise.
    task automatic send_sentence();
        int mode;
        int cut;
        int len;
        int bad;
        if ($urandom_range(0, 99) < 15)
            tx_calm = !tx_calm;
        if ($urandom_range(0, 99) < 8) begin
            len = $urandom_range(1, 12);
            repeat (len) send_char(nrmc_pkg::t_char'($urandom_range(0, 255)),
                                   ROW_PREDICTED, nrmc_pkg::ST_OK);
            return;
        end
        // about one in ten sentences is broken off before field 9 closes
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : 10;
        send_char(nrmc_pkg::CH_DOLLAR, ROW_PREDICTED, nrmc_pkg::ST_OK);

        // type field: good, one letter wrong, short, or long
        len  = 5;
        bad  = 5;
        mode = $urandom_range(0, 99);
        if (mode >= 60 && mode < 80)
            bad = $urandom_range(0, 4);
        else if (mode >= 80 && mode < 90)
            len = $urandom_range(0, 4);
        else if (mode >= 90)
            len = $urandom_range(6, 10);
        for (int i = 0; i < len; i++)
            send_char((i < 5 && i != bad) ? RMC_TYPE[i] : field_char(),
                      ROW_PREDICTED, nrmc_pkg::ST_OK);
        if (cut == 0)
            return;
        send_char(nrmc_pkg::CH_COMMA, ROW_PREDICTED, nrmc_pkg::ST_OK);

        for (int f = 1; f <= 9; f++) begin
            if (f == cut)
                return;
            if (f == nrmc_pkg::FIELD_VALID) begin
                mode = $urandom_range(0, 99);
                if (mode < 80)
                    send_char(nrmc_pkg::CH_A, ROW_PREDICTED, nrmc_pkg::ST_OK);
                else if (mode < 90)
                    send_char(CH_V, ROW_PREDICTED, nrmc_pkg::ST_OK);
                // otherwise the validity field stays empty
                if (mode < 90)
                    repeat ($urandom_range(0, 3))
                        send_char(field_char(), ROW_PREDICTED, nrmc_pkg::ST_OK);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10)
                                                  : $urandom_range(0, 4);
                repeat (len) send_char(field_char(), ROW_PREDICTED, nrmc_pkg::ST_OK);
            end
            send_char(nrmc_pkg::CH_COMMA, ROW_PREDICTED, nrmc_pkg::ST_OK);
        end

        // checksum and line end, all ignored after the verdict
        send_char(CH_STAR, ROW_PREDICTED, nrmc_pkg::ST_OK);
        send_char(nrmc_pkg::t_char'($urandom_range(8'h30, 8'h39)), ROW_PREDICTED,
                  nrmc_pkg::ST_OK);
        send_char(nrmc_pkg::t_char'($urandom_range(8'h41, 8'h46)), ROW_PREDICTED,
                  nrmc_pkg::ST_OK);
        send_char(CH_CR, ROW_PREDICTED, nrmc_pkg::ST_OK);
        send_char(CH_LF, ROW_PREDICTED, nrmc_pkg::ST_OK);
    endtask

    // Receiver back-pressure: stalls of random length, with calm stretches.
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            if ($urandom_range(0, 199) == 0)
                rx_calm <= !rx_calm;
            if (!rx_calm && $urandom_range(0, 99) < 30)
                rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end
    end

    // Status check: every word taken is matched against the oldest status due.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: status word %0d with none due", $time, m_axis_tdata);
            end else begin
                if (m_axis_tdata !== {5'b0, pending_status[0]}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: status expected %0d, got %0d",
                                 $time, pending_status[0], m_axis_tdata);
                end
                void'(pending_status.pop_front());
            end
        end
    end

    // Watchdog: too long with no word moving on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_LEN; k++)
            send_char(DIR_ROWS[k].ch, DIR_ROWS[k].kind, DIR_ROWS[k].st);
        hold_until_drained();

        sent_chars = 0;
        while (sent_chars < RANDOM_CHARS) begin
            send_sentence();
            if ($urandom_range(0, 19) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_status.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> nmea_rmc_sentence_checker.f
rtl/core/nrmc_pkg.sv
rtl/core/nmea_rmc_sentence_checker.sv
test/nmea_rmc_sentence_checker_test.sv
